// File: src/kl_divergence_loss_grad_core_defines.svh
// ----------------------------------------------------------------------------
// KL divergence core assertion macros
// Shared concurrent assertion forms used inside the core's modules.
// ----------------------------------------------------------------------------
`ifndef KL_DIVERGENCE_LOSS_GRAD_CORE_DEFINES_SVH
`define KL_DIVERGENCE_LOSS_GRAD_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define KLD_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kld: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define KLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kld: next-cycle check failed");

`endif

// File: src/kld_pkg.sv
// ----------------------------------------------------------------------------
// KL divergence core package
// Types, constants and state encoding shared by the core's modules.
// ----------------------------------------------------------------------------
package kld_pkg;

    localparam int MAX_ELEMENTS_DEF = 65536;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_ADDR_W-1:0] CFG_EPSILON       = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ELEMENT_COUNT = 1'b1;
    localparam logic [15:0] EPSILON_RST = 16'd1;
    localparam logic [16:0] COUNT_RST   = 17'd1;

    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [4:0]  LOG_ITER   = 5'd16;
    localparam logic [5:0]  GRAD_STEPS = 6'd32;
    localparam logic [5:0]  LOSS_STEPS = 6'd48;

    typedef struct packed {
        logic [15:0] predict_value;
        logic [15:0] label_value;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] gradient_value;
        logic signed [23:0] loss_value;
        logic               loss_valid;
        logic               count_mismatch;
    } out_item_t;

    // Classified element as it waits between the front and the back.
    typedef struct packed {
        logic [15:0] label;
        logic        last;
        logic        p_zero;
        logic        l_zero;
        logic [16:0] a_val;
        logic [16:0] b_val;
        logic [32:0] pn;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [16:0] value;
    } log_req_t;

    typedef struct packed {
        logic        busy;
        logic [20:0] value;
    } log_rsp_t;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [32:0] divisor;
        logic [5:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic [47:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOGA,
        ST_LOGB,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_WDIV,
        ST_DIVL,
        ST_OUT
    } kld_state_t;

endpackage

// File: src/kl_divergence_loss_grad_core.sv
// ----------------------------------------------------------------------------
// KL divergence loss and gradient core
// Streams probability pairs, returns gradient elements and the mean loss.
// ----------------------------------------------------------------------------
//  Channel  Signals                         Transfer when
//  cfg      cfg_we, cfg_addr, cfg_wdata     cfg_we high
//  in       in_valid, in_stall, in_item     in_valid high, in_stall low
//  out      out_valid, out_stall, out_item  out_valid high, out_stall low
//
// In the back end the shared log2 unit runs twice for each element, while
// the divider finds the gradient alongside.
// The element marked last then uses the divider again for the mean loss.
// Reset clears the sum, the element counter and all handshake state.
// The front end takes up to two elements ahead while the back end is busy,
// and a finished result waits in the output register while the next one works.
// ----------------------------------------------------------------------------
module kl_divergence_loss_grad_core #(
    parameter int MAX_ELEMENTS = kld_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kld_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [kld_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  kld_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output kld_pkg::out_item_t              out_item
);

    logic [15:0] epsilon_reg;
    logic [16:0] element_count_reg;

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    kld_pkg::entry_t q_in;
    kld_pkg::entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg       <= kld_pkg::EPSILON_RST;
            element_count_reg <= kld_pkg::COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                kld_pkg::CFG_EPSILON:       epsilon_reg       <= cfg_wdata[15:0];
                kld_pkg::CFG_ELEMENT_COUNT: element_count_reg <= cfg_wdata[16:0];
                default:                    epsilon_reg       <= epsilon_reg;
            endcase
        end
    end

    kld_front u_front (
        .in_valid      (in_valid),
        .in_item       (in_item),
        .in_stall      (in_stall),
        .q_full        (q_full),
        .push          (q_push),
        .entry         (q_in),
        .epsilon       (epsilon_reg),
        .element_count (element_count_reg)
    );

    kld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (q_in),
        .pop       (q_pop),
        .entry_out (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    kld_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .element_count (element_count_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item)
    );

endmodule

// File: src/kld_front.sv
// ----------------------------------------------------------------------------
// KL divergence front end
// Accepts input transfers, classifies them and precomputes operands.
// ----------------------------------------------------------------------------
module kld_front (
    input  logic              in_valid,
    input  kld_pkg::in_item_t in_item,
    output logic              in_stall,
    input  logic              q_full,
    output logic              push,
    output kld_pkg::entry_t   entry,
    input  logic [15:0]       epsilon,
    input  logic [16:0]       element_count
);

    logic [16:0] b_sum;
    logic [16:0] n_eff;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        b_sum = 17'(in_item.predict_value) + 17'(epsilon);
        n_eff = (element_count == 17'd0) ? 17'd1 : element_count;
        entry.label  = in_item.label_value;
        entry.last   = in_item.last_element;
        entry.p_zero = (in_item.predict_value == 16'd0);
        entry.l_zero = (in_item.label_value == 16'd0);
        entry.a_val  = 17'(in_item.label_value) + 17'(epsilon);
        // A zero denominator inside the logarithm is taken as one.
        entry.b_val  = (b_sum == 17'd0) ? 17'd1 : b_sum;
        entry.pn     = 33'(in_item.predict_value) * 33'(n_eff);
    end

endmodule

// File: src/kld_queue.sv
// ----------------------------------------------------------------------------
// KL divergence element queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "kl_divergence_loss_grad_core_defines.svh"

module kld_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  kld_pkg::entry_t entry_in,
    input  logic            pop,
    output kld_pkg::entry_t entry_out,
    output logic            full,
    output logic            empty
);

    localparam int QD    = kld_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QD - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QD);

    kld_pkg::entry_t   slot_reg [QD];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign entry_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

    `KLD_ASSERT_IMPLIES(a_q_pop_nonempty, pop, count_reg != '0)
    `KLD_ASSERT_IMPLIES(a_q_count_bound, 1'b1, count_reg <= CNT_FULL)

endmodule

// File: src/kld_log2.sv
// ----------------------------------------------------------------------------
// KL divergence log2 unit
// Iterative base-2 logarithm, one fraction bit per cycle by squaring.
// ----------------------------------------------------------------------------
module kld_log2 (
    input  logic              clk,
    input  logic              rst_n,
    input  kld_pkg::log_req_t req,
    output kld_pkg::log_rsp_t rsp
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [30:0] x_reg;
    logic [4:0]  k_reg;
    logic [15:0] frac_reg;

    logic [4:0]  k_find;
    logic [30:0] norm;
    logic [61:0] sq;
    logic [31:0] t;

    always_comb
    begin
        k_find = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (req.value[i])
            begin
                k_find = 5'(i);
            end
        end
        // Mantissa in Q1.30 with its leading one at bit 30.
        norm = 31'({14'd0, req.value} << (5'd30 - k_find));
        sq   = 62'(x_reg) * 62'(x_reg);
        t    = sq[61:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= kld_pkg::LOG_ITER;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= norm;
            k_reg    <= k_find;
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= t[31] ? t[31:1] : t[30:0];
            frac_reg <= {frac_reg[14:0], t[31]};
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.value = {k_reg, frac_reg};

endmodule

// File: src/kld_div.sv
// ----------------------------------------------------------------------------
// KL divergence divider
// Restoring divider, one quotient bit per cycle, shared by gradient and loss.
// ----------------------------------------------------------------------------
module kld_div (
    input  logic              clk,
    input  logic              rst_n,
    input  kld_pkg::div_req_t req,
    output kld_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [32:0] divisor_reg;
    logic [47:0] dq_reg;

    logic [33:0] trial;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, dq_reg[47]};
        ge    = (trial >= {1'b0, divisor_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The dividend enters left aligned; quotient bits shift in at the bottom.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
            dq_reg      <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 33'(trial - {1'b0, divisor_reg}) : trial[32:0];
            dq_reg  <= {dq_reg[46:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = dq_reg;

endmodule

// File: src/kld_back.sv
// ----------------------------------------------------------------------------
// KL divergence back end
// Sequences the log and divide units, accumulates terms, forms results.
// ----------------------------------------------------------------------------
`include "kl_divergence_loss_grad_core_defines.svh"

module kld_back #(
    parameter int MAX_ELEMENTS = kld_pkg::MAX_ELEMENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  kld_pkg::entry_t    q_head,
    output logic               q_pop,
    input  logic [16:0]        element_count,
    output logic               out_valid,
    input  logic               out_stall,
    output kld_pkg::out_item_t out_item
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);
    localparam int CMP_W = (CNT_W > 17) ? CNT_W : 17;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_ELEMENTS + 1);
    localparam logic [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
    localparam logic [47:0] SUM_MIN = {1'b1, 47'd0};

    kld_pkg::kld_state_t state_reg, state_next;
    kld_pkg::entry_t     ent_reg;
    kld_pkg::out_item_t  out_item_reg;
    kld_pkg::log_req_t   log_req;
    kld_pkg::log_rsp_t   log_rsp;
    kld_pkg::div_req_t   div_req;
    kld_pkg::div_rsp_t   div_rsp;

    logic [20:0]      la_reg;
    logic [20:0]      dlog_reg;
    logic             neg_reg;
    logic [36:0]      prod1_reg;
    logic [52:0]      prod2_reg;
    logic [47:0]      term_sum_reg, term_sum_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [23:0]      grad_reg;
    logic [23:0]      loss_reg;
    logic             mism_reg;
    logic             loss_neg_reg;
    logic             out_valid_reg, out_valid_next;

    logic        out_free;
    logic        out_load;
    logic [16:0] n_eff;
    logic [47:0] sum_mag;
    logic [48:0] term_ext;
    logic [48:0] sum_ext;
    logic [23:0] grad_val;
    logic [23:0] loss_val;
    logic [23:0] gmag;
    logic [23:0] lmag;
    logic        div_free;
    logic        log_free;

    kld_log2 u_log2 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    kld_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign div_free = !div_rsp.busy;
    assign log_free = !log_rsp.busy;

    always_comb
    begin
        n_eff   = (element_count == 17'd0) ? 17'd1 : element_count;
        sum_mag = term_sum_reg[47] ? 48'(-term_sum_reg) : term_sum_reg;

        term_ext = {19'd0, prod2_reg[52:23]};
        if (neg_reg)
        begin
            term_ext = 49'(-term_ext);
        end
        // Zero labels contribute nothing, whatever the logarithm says.
        if (ent_reg.l_zero)
        begin
            term_ext = '0;
        end
        sum_ext = {term_sum_reg[47], term_sum_reg} + term_ext;

        gmag = (div_rsp.quotient > 48'd8388608) ? 24'h800000 : div_rsp.quotient[23:0];
        grad_val = ent_reg.p_zero ? 24'd0 : 24'(-gmag);

        if (loss_neg_reg)
        begin
            lmag     = (div_rsp.quotient > 48'd8388608) ? 24'h800000
                                                        : div_rsp.quotient[23:0];
            loss_val = 24'(-lmag);
        end
        else
        begin
            lmag     = (div_rsp.quotient > 48'd8388607) ? 24'h7FFFFF
                                                        : div_rsp.quotient[23:0];
            loss_val = lmag;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kld_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = kld_pkg::ST_LOGA;
                end
            end
            kld_pkg::ST_LOGA:
            begin
                if (log_free)
                begin
                    state_next = kld_pkg::ST_LOGB;
                end
            end
            kld_pkg::ST_LOGB:
            begin
                if (log_free)
                begin
                    state_next = kld_pkg::ST_MUL1;
                end
            end
            kld_pkg::ST_MUL1: state_next = kld_pkg::ST_MUL2;
            kld_pkg::ST_MUL2: state_next = kld_pkg::ST_ACC;
            kld_pkg::ST_ACC:  state_next = kld_pkg::ST_WDIV;
            kld_pkg::ST_WDIV:
            begin
                if (div_free)
                begin
                    state_next = ent_reg.last ? kld_pkg::ST_DIVL : kld_pkg::ST_OUT;
                end
            end
            kld_pkg::ST_DIVL:
            begin
                if (div_free)
                begin
                    state_next = kld_pkg::ST_OUT;
                end
            end
            kld_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = kld_pkg::ST_IDLE;
                end
            end
            default: state_next = kld_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        log_req  = '0;
        div_req  = '0;
        unique case (state_reg)
            kld_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop            = 1'b1;
                    log_req.start    = 1'b1;
                    log_req.value    = q_head.a_val;
                    div_req.start    = 1'b1;
                    div_req.dividend = {q_head.label, 32'd0};
                    div_req.divisor  = q_head.pn;
                    div_req.steps    = kld_pkg::GRAD_STEPS;
                end
            end
            kld_pkg::ST_LOGA:
            begin
                if (log_free)
                begin
                    log_req.start = 1'b1;
                    log_req.value = ent_reg.b_val;
                end
            end
            kld_pkg::ST_WDIV:
            begin
                if (div_free && ent_reg.last)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = sum_mag;
                    div_req.divisor  = 33'({n_eff, 8'd0});
                    div_req.steps    = kld_pkg::LOSS_STEPS;
                end
            end
            kld_pkg::ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        term_sum_next  = term_sum_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        if (state_reg == kld_pkg::ST_ACC)
        begin
            if (sum_ext[48] != sum_ext[47])
            begin
                term_sum_next = sum_ext[48] ? SUM_MIN : SUM_MAX;
            end
            else
            begin
                term_sum_next = sum_ext[47:0];
            end
            if (seen_reg != CNT_TOP)
            begin
                seen_next = seen_reg + 1'b1;
            end
        end
        if (state_reg == kld_pkg::ST_WDIV && div_free && ent_reg.last)
        begin
            term_sum_next = '0;
            seen_next     = '0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kld_pkg::ST_IDLE;
            term_sum_reg  <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_sum_reg  <= term_sum_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg <= q_head;
        end
        if (state_reg == kld_pkg::ST_LOGA && log_free)
        begin
            la_reg <= log_rsp.value;
        end
        if (state_reg == kld_pkg::ST_LOGB && log_free)
        begin
            neg_reg  <= (la_reg < log_rsp.value);
            dlog_reg <= (la_reg < log_rsp.value) ? (log_rsp.value - la_reg)
                                                 : (la_reg - log_rsp.value);
        end
        if (state_reg == kld_pkg::ST_MUL1)
        begin
            prod1_reg <= 37'(dlog_reg) * 37'(ent_reg.label);
        end
        if (state_reg == kld_pkg::ST_MUL2)
        begin
            prod2_reg <= 53'(prod1_reg) * 53'(kld_pkg::LN2_Q16);
        end
        if (state_reg == kld_pkg::ST_WDIV && div_free)
        begin
            grad_reg     <= grad_val;
            loss_reg     <= '0;
            loss_neg_reg <= term_sum_reg[47];
            mism_reg     <= ent_reg.last && (CMP_W'(seen_reg) != CMP_W'(element_count));
        end
        if (state_reg == kld_pkg::ST_DIVL && div_free)
        begin
            loss_reg <= loss_val;
        end
        if (out_load)
        begin
            out_item_reg.gradient_value <= grad_reg;
            out_item_reg.loss_value     <= loss_reg;
            out_item_reg.loss_valid     <= ent_reg.last;
            out_item_reg.count_mismatch <= mism_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `KLD_ASSERT_IMPLIES(a_div_start_idle, div_req.start, !div_rsp.busy)
    `KLD_ASSERT_NEXT(a_log_started, state_reg == kld_pkg::ST_IDLE && !q_empty, log_rsp.busy)
    `KLD_ASSERT_IMPLIES(a_sum_cleared, state_reg == kld_pkg::ST_OUT && ent_reg.last,
        term_sum_reg == '0 && seen_reg == '0)

endmodule
